FILE: sv/rzdm_pkg.sv
// ----------------------------------------------------------------------------
// rzdm_pkg
// Shared constants, types and helpers of the rotozoom displacement map.
// ----------------------------------------------------------------------------
package rzdm_pkg;

    localparam int MAX_SIDE   = 128;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int COORD_W    = $clog2(MAX_SIDE);

    localparam int PIXEL_W    = 7;
    localparam int S_TDATA_W  = 16;
    localparam int TRIG_W     = 16;
    localparam int CFG_SIZE_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COSINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

    localparam logic [TRIG_W-1:0]     RST_COSINE = 16'h7FFF;
    localparam logic [TRIG_W-1:0]     RST_SINE   = 16'h0000;
    localparam logic [TRIG_W-1:0]     RST_ZOOM   = 16'h0040;
    localparam logic [CFG_SIZE_W-1:0] RST_SIDE   = 8'd48;

    localparam int MAC_A_W    = 17;
    localparam int MAC_B_W    = 17;
    localparam int ACC_W      = 34;
    localparam int ROUND_BIAS = 16384;
    localparam int ROT_SHIFT  = 6;
    localparam int ZOOM_SHIFT = 15;
    localparam int CLAMP_W    = ACC_W - ZOOM_SHIFT + 1;

    localparam int DIFF_W     = 16;
    localparam int SLOT_W     = 10;
    localparam int PARTIAL_W  = 20;
    localparam int WORD_W     = 32;
    localparam int SLOT2_LSB  = 22;

    typedef logic [1:0] slot_cnt_t;
    localparam slot_cnt_t SLOT_FIRST  = 2'd0;
    localparam slot_cnt_t SLOT_SECOND = 2'd1;
    localparam slot_cnt_t SLOT_THIRD  = 2'd2;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [DIFF_W-1:0] diff;
    } pack_req_t;

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [ACC_W-1:0] prod,
        input logic [SIDE_W-2:0]       half,
        input logic [COORD_W-1:0]      hi
    );
        logic [CLAMP_W-1:0] v;
        logic [COORD_W-1:0] r;
        v = CLAMP_W'(prod >>> ZOOM_SHIFT) + CLAMP_W'(half);
        if (v[CLAMP_W-1]) begin
            r = '0;
        end else if (v > CLAMP_W'(hi)) begin
            r = hi;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/rotozoom_displacement_map.sv
// ----------------------------------------------------------------------------
// rotozoom_displacement_map
// Rotate-and-zoom source lookup per destination pixel, emitting packed
// 10-bit index differences three to a 32-bit word.
// Sequence: each accepted item makes eight passes through the one shared
// 17x17 multiply-accumulate unit, then a pack step that waits on output
// backpressure; no new item is accepted until the sequencer returns to idle.
// Reset: synchronous, active low; clears the sequencer, packing state and
// output valid, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module rotozoom_displacement_map (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rzdm_pkg::S_TDATA_W-1:0]      s_tdata,   // pixel_x, pixel_y
    input  logic                                s_tlast,   // last_pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rzdm_pkg::WORD_W-1:0]         m_tdata,   // packed_word
    output logic                                m_tlast,   // end_of_map
    output logic                                m_tuser,   // offset_overflow
    input  logic                                cfg_wr_en,
    input  logic [rzdm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rzdm_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import rzdm_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_RX0  = 10'b0000000010,
        ST_RX1  = 10'b0000000100,
        ST_RY0  = 10'b0000001000,
        ST_RY1  = 10'b0000010000,
        ST_ZX   = 10'b0000100000,
        ST_ZY   = 10'b0001000000,
        ST_DST  = 10'b0010000000,
        ST_SRC  = 10'b0100000000,
        ST_PACK = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [TRIG_W-1:0] cosine_reg;
    logic signed [TRIG_W-1:0] sine_reg;
    logic                     mirror_reg;
    logic signed [TRIG_W-1:0] zoom_reg;
    logic [CFG_SIZE_W-1:0]    width_reg;
    logic [CFG_SIZE_W-1:0]    height_reg;

    logic signed [PIXEL_W-1:0] px_reg;
    logic signed [PIXEL_W-1:0] py_reg;
    logic                      last_reg;
    logic signed [TRIG_W-1:0]  rx_reg;
    logic signed [TRIG_W-1:0]  ry_reg;
    logic [COORD_W-1:0]        sx_reg;
    logic [COORD_W-1:0]        sy_reg;
    logic [DIFF_W-1:0]         dest_reg;

    logic [SIDE_W-1:0]  w_side;
    logic [SIDE_W-1:0]  h_side;
    logic [SIDE_W-2:0]  half_w;
    logic [SIDE_W-2:0]  half_h;
    logic [COORD_W-1:0] hi_w;
    logic [COORD_W-1:0] hi_h;

    logic signed [MAC_B_W-1:0] cos_b;
    logic signed [MAC_B_W-1:0] sn_b;
    logic signed [MAC_B_W-1:0] w_b;
    logic signed [MAC_A_W-1:0] op_a;
    logic signed [MAC_B_W-1:0] op_b;
    logic signed [ACC_W-1:0]   op_c;
    logic signed [ACC_W-1:0]   acc;
    logic                      mac_en;

    pack_req_t pack_req;
    logic      pack_ready;
    logic      s_accept;

    assign w_side = (int'(width_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(width_reg);
    assign h_side = (int'(height_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(height_reg);
    assign half_w = w_side[SIDE_W-1:1];
    assign half_h = h_side[SIDE_W-1:1];
    assign hi_w   = (w_side == '0) ? '0 : COORD_W'(w_side - SIDE_W'(1));
    assign hi_h   = (h_side == '0) ? '0 : COORD_W'(h_side - SIDE_W'(1));

    assign cos_b = MAC_B_W'(cosine_reg);
    assign sn_b  = mirror_reg ? -MAC_B_W'(sine_reg) : MAC_B_W'(sine_reg);
    assign w_b   = MAC_B_W'({1'b0, w_side});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cosine_reg <= RST_COSINE;
            sine_reg   <= RST_SINE;
            mirror_reg <= 1'b0;
            zoom_reg   <= RST_ZOOM;
            width_reg  <= RST_SIDE;
            height_reg <= RST_SIDE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COSINE: cosine_reg <= cfg_wr_data[TRIG_W-1:0];
                CFG_SINE:   sine_reg   <= cfg_wr_data[TRIG_W-1:0];
                CFG_MIRROR: mirror_reg <= cfg_wr_data[0];
                CFG_ZOOM:   zoom_reg   <= cfg_wr_data[TRIG_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_wr_data[CFG_SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wr_data[CFG_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_c   = '0;
        mac_en = 1'b1;
        case (state_reg)
            ST_RX0: begin
                op_a = MAC_A_W'(px_reg);
                op_b = cos_b;
                op_c = ACC_W'(ROUND_BIAS);
            end
            ST_RX1: begin
                op_a = MAC_A_W'(py_reg);
                op_b = -sn_b;
                op_c = acc;
            end
            ST_RY0: begin
                op_a = MAC_A_W'(px_reg);
                op_b = sn_b;
                op_c = ACC_W'(ROUND_BIAS);
            end
            ST_RY1: begin
                op_a = MAC_A_W'(py_reg);
                op_b = cos_b;
                op_c = acc;
            end
            ST_ZX: begin
                op_a = MAC_A_W'(rx_reg);
                op_b = MAC_B_W'(zoom_reg);
            end
            ST_ZY: begin
                op_a = MAC_A_W'(ry_reg);
                op_b = MAC_B_W'(zoom_reg);
            end
            ST_DST: begin
                op_a = MAC_A_W'(py_reg) + MAC_A_W'({1'b0, half_h});
                op_b = w_b;
                op_c = ACC_W'(px_reg) + ACC_W'({1'b0, half_w});
            end
            ST_SRC: begin
                op_a = MAC_A_W'({1'b0, sy_reg});
                op_b = w_b;
                op_c = ACC_W'({1'b0, sx_reg});
            end
            default: mac_en = 1'b0;
        endcase
    end

    rzdm_mac u_mac (
        .aclk (aclk),
        .en   (mac_en),
        .op_a (op_a),
        .op_b (op_b),
        .op_c (op_c),
        .acc  (acc)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_RX0;
            ST_RX0:  state_next = ST_RX1;
            ST_RX1:  state_next = ST_RY0;
            ST_RY0:  state_next = ST_RY1;
            ST_RY1:  state_next = ST_ZX;
            ST_ZX:   state_next = ST_ZY;
            ST_ZY:   state_next = ST_DST;
            ST_DST:  state_next = ST_SRC;
            ST_SRC:  state_next = ST_PACK;
            ST_PACK: if (pack_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg   <= s_tdata[PIXEL_W-1:0];
            py_reg   <= s_tdata[2*PIXEL_W-1:PIXEL_W];
            last_reg <= s_tlast;
        end
        if (state_reg == ST_RY0) rx_reg   <= acc[TRIG_W+ROT_SHIFT-1:ROT_SHIFT];
        if (state_reg == ST_ZX)  ry_reg   <= acc[TRIG_W+ROT_SHIFT-1:ROT_SHIFT];
        if (state_reg == ST_ZY)  sx_reg   <= clamp_coord(acc, half_w, hi_w);
        if (state_reg == ST_DST) sy_reg   <= clamp_coord(acc, half_h, hi_h);
        if (state_reg == ST_SRC) dest_reg <= acc[DIFF_W-1:0];
    end

    assign pack_req.valid = (state_reg == ST_PACK);
    assign pack_req.last  = last_reg;
    assign pack_req.diff  = dest_reg - acc[DIFF_W-1:0];

    rzdm_packer u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (pack_req),
        .req_ready (pack_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_RX0)
        else $error("accepted item did not start the sequence");

    a_valid_from_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_PACK))
        else $error("result appeared outside the pack step");

    a_pack_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PACK && pack_ready) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after packing");

endmodule

FILE: sv/rzdm_mac.sv
// ----------------------------------------------------------------------------
// rzdm_mac
// Shared signed multiply-accumulate unit with a registered result.
// ----------------------------------------------------------------------------
module rzdm_mac (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [rzdm_pkg::MAC_A_W-1:0] op_a,
    input  logic signed [rzdm_pkg::MAC_B_W-1:0] op_b,
    input  logic signed [rzdm_pkg::ACC_W-1:0]   op_c,
    output logic signed [rzdm_pkg::ACC_W-1:0]   acc
);
    import rzdm_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign acc_next = op_c + op_a * op_b;

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: sv/rzdm_packer.sv
// ----------------------------------------------------------------------------
// rzdm_packer
// Gathers three 10-bit differences per word and holds the output register.
// ----------------------------------------------------------------------------
module rzdm_packer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rzdm_pkg::pack_req_t                req,
    output logic                               req_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rzdm_pkg::WORD_W-1:0]        m_tdata,   // packed_word
    output logic                               m_tlast,   // end_of_map
    output logic                               m_tuser    // offset_overflow
);
    import rzdm_pkg::*;

    logic [PARTIAL_W-1:0] partial_reg, partial_next;
    slot_cnt_t            slot_reg, slot_next;
    logic                 ovf_reg, ovf_next;
    logic                 valid_reg, valid_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic                 last_reg, last_next;
    logic                 flag_reg, flag_next;

    logic                 take;
    logic                 ovf_now;
    logic                 ovf_any;
    logic [SLOT_W-1:0]    bits;
    logic [PARTIAL_W-1:0] merged;

    assign req_ready = !valid_reg || m_tready;
    assign take      = req.valid && req_ready;
    assign bits      = req.diff[SLOT_W-1:0];
    assign ovf_now   = !((&req.diff[DIFF_W-1:SLOT_W-1]) || !(|req.diff[DIFF_W-1:SLOT_W-1]));
    assign ovf_any   = ovf_reg || ovf_now;

    always_comb begin
        case (slot_reg)
            SLOT_FIRST:  merged = PARTIAL_W'(bits);
            SLOT_SECOND: merged = {bits, partial_reg[SLOT_W-1:0]};
            default:     merged = partial_reg;
        endcase
    end

    always_comb begin
        partial_next = partial_reg;
        slot_next    = slot_reg;
        ovf_next     = ovf_reg;
        valid_next   = valid_reg && !m_tready;
        word_next    = word_reg;
        last_next    = last_reg;
        flag_next    = flag_reg;
        if (take) begin
            if (slot_reg == SLOT_THIRD || req.last) begin
                valid_next   = 1'b1;
                last_next    = req.last;
                flag_next    = ovf_any;
                partial_next = '0;
                slot_next    = SLOT_FIRST;
                ovf_next     = 1'b0;
                if (slot_reg == SLOT_THIRD) begin
                    word_next = {bits, 2'b00, partial_reg};
                end else begin
                    word_next = WORD_W'(merged);
                end
            end else begin
                partial_next = merged;
                slot_next    = slot_reg + 2'd1;
                ovf_next     = ovf_any;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            slot_reg    <= SLOT_FIRST;
            ovf_reg     <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            partial_reg <= partial_next;
            slot_reg    <= slot_next;
            ovf_reg     <= ovf_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        last_reg <= last_next;
        flag_reg <= flag_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = flag_reg;

endmodule

FILE: test/rzdm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rzdm_checker
// Watches the pixel, word and register ports of the rotozoom displacement
// map, predicts every packed offset word from the accepted pixels and the
// register values in force, and compares each delivered word field by field.
// ----------------------------------------------------------------------------
module rzdm_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rzdm_pkg::S_TDATA_W-1:0]    s_tdata,   // pixel_x, pixel_y
    input  logic                              s_tlast,   // last_pixel
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rzdm_pkg::WORD_W-1:0]       m_tdata,   // packed_word
    input  logic                              m_tlast,   // end_of_map
    input  logic                              m_tuser,   // offset_overflow
    input  logic                              cfg_wr_en,
    input  logic [rzdm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rzdm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output int                                mismatch_count,
    output int                                words_due
);
    import rzdm_pkg::*;

    localparam int OFFSET_LIMIT = 512;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              end_of_map;
        logic              overflow;
    } map_word_t;

    map_word_t pending_words[$];

    logic signed [TRIG_W-1:0] cos_q;
    logic signed [TRIG_W-1:0] sin_q;
    logic signed [TRIG_W-1:0] zoom_q;
    logic                     mirror_q;
    logic [CFG_SIZE_W-1:0]    width_q;
    logic [CFG_SIZE_W-1:0]    height_q;
    logic [PARTIAL_W-1:0]     partial_q;
    slot_cnt_t                slots_q;
    logic                     ovf_q;

    function automatic int side_of(input logic [CFG_SIZE_W-1:0] s);
        return (s > MAX_SIDE) ? MAX_SIDE : int'(s);
    endfunction

    function automatic int clamp_to(input int v, input int size);
        int hi;
        hi = (size > 0) ? size - 1 : 0;
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return v;
    endfunction

    task automatic displace_pixel(input logic [S_TDATA_W-1:0] data, input logic last);
        int px, py, w, h, hw, hh, cs, sn, rx, ry, sx, sy, dest, src;
        logic signed [15:0] rot_x, rot_y;
        logic [DIFF_W-1:0]  diff;
        logic [SLOT_W-1:0]  slot;
        map_word_t          result;
        px = int'($signed(data[PIXEL_W-1:0]));
        py = int'($signed(data[2*PIXEL_W-1:PIXEL_W]));
        w = side_of(width_q);
        h = side_of(height_q);
        hw = w / 2;
        hh = h / 2;
        cs = int'(cos_q);
        sn = mirror_q ? -int'(sin_q) : int'(sin_q);
        rx = (px * cs - py * sn + ROUND_BIAS) >>> ROT_SHIFT;
        ry = (px * sn + py * cs + ROUND_BIAS) >>> ROT_SHIFT;
        rot_x = 16'(rx);
        rot_y = 16'(ry);
        sx = clamp_to(((int'(rot_x) * int'(zoom_q)) >>> ZOOM_SHIFT) + hw, w);
        sy = clamp_to(((int'(rot_y) * int'(zoom_q)) >>> ZOOM_SHIFT) + hh, h);
        dest = (py + hh) * w + (px + hw);
        src = sx + sy * w;
        diff = DIFF_W'(dest - src);
        slot = diff[SLOT_W-1:0];
        if ($signed(diff) < -OFFSET_LIMIT || $signed(diff) > OFFSET_LIMIT - 1) ovf_q = 1'b1;
        case (slots_q)
            SLOT_FIRST: begin
                partial_q = PARTIAL_W'(slot);
                slots_q = SLOT_SECOND;
            end
            SLOT_SECOND: begin
                partial_q = partial_q | (PARTIAL_W'(slot) << SLOT_W);
                slots_q = SLOT_THIRD;
            end
            default: begin
                result.word = {slot, 2'b00, partial_q};
                result.end_of_map = last;
                result.overflow = ovf_q;
                pending_words.push_back(result);
                partial_q = '0;
                slots_q = SLOT_FIRST;
                ovf_q = 1'b0;
                return;
            end
        endcase
        if (last) begin
            result.word = {12'b0, partial_q};
            result.end_of_map = 1'b1;
            result.overflow = ovf_q;
            pending_words.push_back(result);
            partial_q = '0;
            slots_q = SLOT_FIRST;
            ovf_q = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        map_word_t want;
        if (!aresetn) begin
            cos_q = RST_COSINE;
            sin_q = RST_SINE;
            zoom_q = RST_ZOOM;
            mirror_q = 1'b0;
            width_q = RST_SIDE;
            height_q = RST_SIDE;
            partial_q = '0;
            slots_q = SLOT_FIRST;
            ovf_q = 1'b0;
            mismatch_count = 0;
            pending_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_COSINE: cos_q = cfg_wr_data;
                    CFG_SINE:   sin_q = cfg_wr_data;
                    CFG_MIRROR: mirror_q = cfg_wr_data[0];
                    CFG_ZOOM:   zoom_q = cfg_wr_data;
                    CFG_WIDTH:  width_q = cfg_wr_data[CFG_SIZE_W-1:0];
                    CFG_HEIGHT: height_q = cfg_wr_data[CFG_SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) displace_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected word %h last %b ovf %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (m_tdata !== want.word) begin
                        $display("%0t: packed_word expected %h actual %h",
                                 $time, want.word, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.end_of_map) begin
                        $display("%0t: end_of_map expected %b actual %b",
                                 $time, want.end_of_map, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.overflow) begin
                        $display("%0t: offset_overflow expected %b actual %b",
                                 $time, want.overflow, m_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
        words_due = pending_words.size();
    end

endmodule

FILE: test/tb_rotozoom_displacement_map.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotozoom_displacement_map
// Drives pixel maps through the rotozoom displacement map under a series of
// register settings, with random idle gaps on both streams, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_rotozoom_displacement_map;
    import rzdm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int TARGET_PIXELS = 1900;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [WORD_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int mismatch_count;
    int words_due;
    int pixels_sent = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    int cur_w = 48;
    int cur_h = 48;

    rotozoom_displacement_map dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    rzdm_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .mismatch_count(mismatch_count), .words_due(words_due)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clip_side(input int s);
        return (s > MAX_SIDE) ? MAX_SIDE : s;
    endfunction

    function automatic logic [PIXEL_W-1:0] rand_coord(input int size);
        int s;
        s = clip_side(size);
        if (s < 2 || $urandom_range(0, 3) == 0) return PIXEL_W'($urandom);
        return PIXEL_W'(int'($urandom_range(0, s - 1)) - s / 2);
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return 1;
            2: return 128;
            3: return 129;
            4: return 255;
            5: return 2 * $urandom_range(1, 4) + 1;
            default: return $urandom_range(2, 16) * ($urandom_range(0, 1) ? 1 : 8);
        endcase
    endfunction

    // hold m_tready low for a random stretch now and then
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20) stall_left = idle_gap();
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic [PIXEL_W-1:0] py,
                              input logic last);
        int g;
        g = idle_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata <= {2'b00, py, px};
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (words_due != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
    endtask

    task automatic program_map(input logic [15:0] cs, input logic [15:0] sn, input logic mir,
                               input logic [15:0] zm, input int w, input int h);
        drain();
        write_reg(CFG_COSINE, cs);
        write_reg(CFG_SINE, sn);
        write_reg(CFG_MIRROR, {15'($urandom), mir});
        write_reg(CFG_ZOOM, zm);
        write_reg(CFG_WIDTH, {8'($urandom), 8'(w)});
        write_reg(CFG_HEIGHT, {8'($urandom), 8'(h)});
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom));
        cfg_wr_en <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    task automatic scan_window();
        int sw, sh, cw, ch;
        sw = clip_side(cur_w);
        sh = clip_side(cur_h);
        cw = (sw < 8) ? sw : 8;
        ch = (sh < 6) ? sh : 6;
        for (int j = 0; j < ch; j++) begin
            for (int i = 0; i < cw; i++) begin
                send_pixel(PIXEL_W'(i - sw / 2), PIXEL_W'(j - sh / 2),
                           (i == cw - 1) && (j == ch - 1));
            end
        end
    endtask

    task automatic random_map();
        int n;
        bit broken;
        n = $urandom_range(1, 60);
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++) begin
            send_pixel(rand_coord(cur_w), rand_coord(cur_h), (i == n - 1) && !broken);
        end
    endtask

    initial begin
        int phase_end;
        int kind;
        logic [15:0] cs, sn, zm;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: full word with last, one- and two-slot flush, plain word
        send_pixel(-7'sd64, -7'sd64, 1'b0);
        send_pixel(7'sd63, 7'sd63, 1'b0);
        send_pixel(7'sd0, 7'sd0, 1'b1);
        send_pixel(7'sd5, -7'sd3, 1'b1);
        send_pixel(-7'sd1, 7'sd2, 1'b0);
        send_pixel(7'sd10, -7'sd20, 1'b1);
        send_pixel(-7'sd24, -7'sd24, 1'b0);
        send_pixel(7'sd23, 7'sd23, 1'b0);
        send_pixel(-7'sd24, 7'sd23, 1'b0);

        // large offsets overflow
        program_map(16'h0000, 16'h7FFF, 1'b1, 16'h8000, 128, 128);
        send_pixel(7'sd63, -7'sd64, 1'b0);
        send_pixel(-7'sd64, 7'sd63, 1'b0);
        send_pixel(7'sd63, 7'sd63, 1'b1);
        send_pixel(-7'sd64, -7'sd64, 1'b1);

        // empty width, oversized height
        program_map(16'h8000, 16'h8000, 1'b0, 16'h7FFF, 0, 255);
        send_pixel(7'sd0, 7'sd0, 1'b0);
        send_pixel(-7'sd64, 7'sd0, 1'b0);
        send_pixel(7'sd0, 7'sd63, 1'b1);

        // odd sizes, zero zoom
        program_map(16'h7FFF, 16'h8000, 1'b1, 16'h0000, 3, 129);
        send_pixel(7'sd1, -7'sd1, 1'b0);
        send_pixel(-7'sd2, 7'sd1, 1'b0);
        send_pixel(7'sd0, 7'sd0, 1'b1);

        while (pixels_sent < TARGET_PIXELS) begin
            if ($urandom_range(0, 4) == 0) begin
                cs = pick_extreme();
                sn = pick_extreme();
                zm = pick_extreme();
            end else begin
                cs = 16'($urandom);
                sn = 16'($urandom);
                zm = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 512)) - 256)
                                          : 16'($urandom);
            end
            program_map(cs, sn, 1'($urandom), zm, pick_size(), pick_size());
            calm = ($urandom_range(0, 3) == 0);
            phase_end = pixels_sent + $urandom_range(40, 200);
            while (pixels_sent < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind < 2) begin
                    send_pixel(PIXEL_W'($urandom), PIXEL_W'($urandom), ($urandom_range(0, 9) == 0));
                end else if (kind < 5 && clip_side(cur_w) >= 2 && clip_side(cur_h) >= 2) begin
                    scan_window();
                end else begin
                    random_map();
                end
            end
            calm = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (words_due != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
